// File: sv/irpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared widths, register indexes and codes of the pulse-width byte deframer.
// ----------------------------------------------------------------------------
package irpw_pkg;

  localparam int INTERVAL_BITS = 24;
  localparam int TICK_BITS     = 24;
  localparam int IN_FIELD_BITS = 24;
  // interval bits actually used, never more than the input field carries
  localparam int DELAY_BITS    = (INTERVAL_BITS < IN_FIELD_BITS) ? INTERVAL_BITS
                                                                 : IN_FIELD_BITS;
  localparam int DIVIDEND_BITS = TICK_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
  localparam int BITCNT_BITS   = 4;
  localparam int CFG_IDX_BITS  = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_BIT   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_BIT    = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GLITCH_MIN = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAP_MAX    = 8'd3;

  localparam logic [TICK_BITS-1:0] HIGH_BIT_RESET   = 24'd4167;
  localparam logic [TICK_BITS-1:0] LOW_BIT_RESET    = 24'd4167;
  localparam logic [TICK_BITS-1:0] GLITCH_MIN_RESET = 24'd500;
  localparam logic [TICK_BITS-1:0] GAP_MAX_RESET    = 24'd50000;

  localparam logic [3:0] DATA_BITS = 4'd8;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DATA   = 2'd1,
    PH_PARITY = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_FRAME = 4'b1000
  } state_t;

  typedef struct packed {
    logic                   done;
    logic                   sat;
    logic [BITCNT_BITS-1:0] quot;
  } div_res_t;

endpackage

// File: sv/irpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_div
// Restoring serial divider, one quotient bit per cycle. The quotient is kept
// to its low bits with a sticky flag for anything larger.
// ----------------------------------------------------------------------------
module irpw_div
  import irpw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [TICK_BITS-1:0]     divisor,
  output div_res_t                 res
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_BITS-1:0] dvd_r, dvd_nxt;
  logic [TICK_BITS-1:0]     rem_r, rem_nxt;
  logic [TICK_BITS-1:0]     dsr_r, dsr_nxt;
  logic [BITCNT_BITS-1:0]   q_r, q_nxt;
  logic                     sat_r, sat_nxt;
  logic [TICK_BITS:0]       trial;
  logic [TICK_BITS:0]       diff;
  logic                     qbit;

  assign trial = {rem_r, dvd_r[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_nxt = qbit ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
      dvd_nxt = {dvd_r[DIVIDEND_BITS-2:0], 1'b0};
      q_nxt   = {q_r[BITCNT_BITS-2:0], qbit};
      sat_nxt = sat_r | q_r[BITCNT_BITS-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.quot = q_r;

endmodule

// File: sv/ir_pulse_width_byte_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_byte_deframer
// Byte deframer for an inverted infrared serial line fed with edge intervals.
// ----------------------------------------------------------------------------
// Each transfer on the input carries the tick count between two line edges.
// An interval passes through the limit checks, then the serial divider that
// turns the interval into a bit count (one quotient bit per cycle for 25 bits,
// then a registered completion flag), then the framer update before ready
// returns. Intervals below the glitch limit return to ready straight from the
// limit checks. A received byte whose parity matches sits in an output
// register; the framer update waits only if an earlier byte has not yet been
// taken. Configuration writes are always accepted and should be issued while
// no interval is in flight.
// ----------------------------------------------------------------------------
module ir_pulse_width_byte_deframer
  import irpw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // tdata: [23:0] interval_ticks
  input  logic [23:0]             in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata: [7:0] rx_byte
  output logic [7:0]              out_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]    cfg_data
);

  state_t                   state_r, state_nxt;
  logic [TICK_BITS-1:0]     high_bit_r, low_bit_r, glitch_min_r, gap_max_r;
  logic [TICK_BITS-1:0]     delay_r, delay_nxt;
  logic                     lvl_r, lvl_nxt;
  phase_t                   ph_r, ph_nxt;
  logic [3:0]               pos_r, pos_nxt;
  logic [7:0]               sb_r, sb_nxt;
  logic                     par_r, par_nxt;
  logic                     short_r, short_nxt;
  logic [7:0]               out_data_r, out_data_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [TICK_BITS-1:0]     nominal;
  logic [DIVIDEND_BITS-1:0] dividend;
  logic                     lvl_chk;
  phase_t                   ph_chk;
  logic                     div_start;
  div_res_t                 div_res;

  logic [BITCNT_BITS-1:0]   bits;
  logic [3:0]               room, take;
  logic                     emit;
  logic [7:0]               emit_byte;
  logic                     frame_go;

  irpw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (nominal),
    .res      (div_res)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // long gap resynchronizes before the bit time is chosen
  always_comb begin
    lvl_chk = lvl_r;
    ph_chk  = ph_r;
    if (delay_r > gap_max_r) begin
      lvl_chk = 1'b0;
      ph_chk  = PH_STOP;
    end
    nominal = lvl_chk ? low_bit_r : high_bit_r;
    if (nominal == '0) begin
      nominal = TICK_BITS'(1);
    end
    dividend = {1'b0, delay_r} + {2'b00, nominal[TICK_BITS-1:1]};
  end

  assign div_start = (state_r == S_CHECK) && (delay_r >= glitch_min_r);
  assign frame_go  = !out_valid_r || out_tready;

  // framer update for one interval
  always_comb begin
    lvl_nxt   = lvl_r;
    ph_nxt    = ph_r;
    pos_nxt   = pos_r;
    sb_nxt    = sb_r;
    par_nxt   = par_r;
    emit      = 1'b0;
    emit_byte = sb_r;
    room      = '0;
    take      = '0;
    if (short_r) begin
      bits = BITCNT_BITS'(1);
    end else if (div_res.sat) begin
      bits = '1;
    end else begin
      bits = div_res.quot;
    end

    if (ph_nxt == PH_START && lvl_r && bits != '0) begin
      bits    = bits - 1'b1;
      ph_nxt  = PH_DATA;
      par_nxt = 1'b0;
      pos_nxt = '0;
      sb_nxt  = '0;
    end

    if (ph_nxt == PH_DATA && bits != '0) begin
      room = DATA_BITS - pos_nxt;
      take = (bits < room) ? bits : room;
      if (!lvl_r) begin
        for (int i = 0; i < 8; i++) begin
          if (4'(i) >= pos_nxt && 4'(i) < pos_nxt + take) begin
            sb_nxt[i] = 1'b1;
          end
        end
        par_nxt = par_nxt ^ take[0];
      end
      pos_nxt = pos_nxt + take;
      bits    = bits - take;
      if (pos_nxt >= DATA_BITS) begin
        ph_nxt = PH_PARITY;
      end
    end

    if (ph_nxt == PH_PARITY && bits != '0) begin
      emit_byte = sb_nxt;
      emit      = (par_nxt == lvl_r);
      sb_nxt    = '0;
      ph_nxt    = PH_STOP;
      bits      = bits - 1'b1;
    end

    if (ph_nxt == PH_STOP && bits != '0 && !lvl_r) begin
      ph_nxt = PH_START;
    end

    lvl_nxt = ~lvl_r;
  end

  always_comb begin
    state_nxt     = state_r;
    delay_nxt     = delay_r;
    short_nxt     = short_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          delay_nxt = TICK_BITS'(in_tdata[DELAY_BITS-1:0]);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (div_start) begin
          short_nxt = (delay_r <= nominal);
          state_nxt = S_DIV;
        end else begin
          // drop a glitch: no toggle, no change
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_FRAME;
        end
      end
      S_FRAME: begin
        if (frame_go) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = emit_byte;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      high_bit_r   <= HIGH_BIT_RESET;
      low_bit_r    <= LOW_BIT_RESET;
      glitch_min_r <= GLITCH_MIN_RESET;
      gap_max_r    <= GAP_MAX_RESET;
      lvl_r        <= 1'b0;
      ph_r         <= PH_STOP;
      pos_r        <= '0;
      sb_r         <= '0;
      par_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_HIGH_BIT:   high_bit_r   <= cfg_data;
          REG_LOW_BIT:    low_bit_r    <= cfg_data;
          REG_GLITCH_MIN: glitch_min_r <= cfg_data;
          REG_GAP_MAX:    gap_max_r    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (div_start) begin
        lvl_r <= lvl_chk;
        ph_r  <= ph_chk;
      end else if (state_r == S_FRAME && frame_go) begin
        lvl_r <= lvl_nxt;
        ph_r  <= ph_nxt;
        pos_r <= pos_nxt;
        sb_r  <= sb_nxt;
        par_r <= par_nxt;
      end
    end
    delay_r    <= delay_nxt;
    short_r    <= short_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
